/* sv/hierarchical_occlusion_map_query_unit_defines.svh */
// assertion helpers shared by the occlusion map query unit
`ifndef HIERARCHICAL_OCCLUSION_MAP_QUERY_UNIT_DEFINES_SVH
`define HIERARCHICAL_OCCLUSION_MAP_QUERY_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define HMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hmq assertion failed");

// consequent checked in the cycle after the antecedent
`define HMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hmq assertion failed");

`endif

/* sv/hmq_pkg.sv */
`default_nettype none
package hmq_pkg;

  localparam int MaxSide    = 256;
  localparam int MaxLevels  = 7;
  localparam int MaxLog     = $clog2(MaxSide);
  localparam int LogW       = 4;
  localparam int CoordW     = 8;
  localparam int LvlW       = 3;
  localparam int StoreDepth = MaxSide * MaxSide / 3 * 4 + 16;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam logic [7:0] Opaque = 8'd255;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_VISIBLE  = 3'd1,
    ST_OCCLUDED = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_DEGEN    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] y1;
  } frame_t;

  typedef struct packed {
    logic    load;
    logic    wr_pixel;
    logic    q_calc;
    logic    b_init;
    logic    b_rd;
    logic    b_wr;
    logic    w_start;
    logic    w_desc;
    logic    w_rd;
    logic    w_adv;
    logic    w_pop;
    logic    res_set;
    logic    res_top;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    op_t     op;
    logic    b_empty;
    logic    b_k3;
    logic    b_last;
    status_t q_res;
    logic    f_empty;
    logic    f_end;
    logic    at_top;
    logic    lvl_zero;
    logic    pix_clear;
  } stat_t;

  // every level side is a power of two, so the offsets never carry
  function automatic logic [AddrW-1:0] lvl_base(logic [LogW-1:0] lg, logic [LvlW-1:0] l);
    logic [AddrW-1:0] b;
    logic [LogW:0]    e;
    b = '0;
    for (int k = 0; k < MaxLevels; k++) begin
      e = {1'b0, lg} - (LogW+1)'(k);
      if (l > LvlW'(k)) begin
        b = b | (AddrW'(1) << {e, 1'b0});
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

/* sv/hierarchical_occlusion_map_query_unit.sv */
`default_nettype none
// Occlusion pyramid with base side 2^side_log2 (4 to 256) and side_log2-1 levels, plus
// a rectangle visibility query. One item is in work at a time, one result per item.
// A build does four single-port reads and a write per coarse pixel; a query that is off
// the map or degenerate returns without a walk, otherwise its depth-first walk makes one
// store read per pyramid pixel it visits.
// The store holds no reset state and needs no clearing pass; read only written pixels.
// side_log2 may be written only while no item is in work.
module hierarchical_occlusion_map_query_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [3:0]         cfg_wdata,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         in_op,
  input  wire  [7:0]         in_pixel_x,
  input  wire  [7:0]         in_pixel_y,
  input  wire  [7:0]         in_pixel_value,
  input  wire  signed [15:0] in_rect_min_x,
  input  wire  signed [15:0] in_rect_max_x,
  input  wire  signed [15:0] in_rect_min_y,
  input  wire  signed [15:0] in_rect_max_y,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [2:0]         out_status,
  output logic [2:0]         out_start_level
);
  import hmq_pkg::*;

  `include "hierarchical_occlusion_map_query_unit_defines.svh"

  cmd_t  cmd;
  stat_t st;

  hmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  hmq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_op),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_pixel_value  (in_pixel_value),
    .in_rect_min_x   (in_rect_min_x),
    .in_rect_max_x   (in_rect_max_x),
    .in_rect_min_y   (in_rect_min_y),
    .in_rect_max_y   (in_rect_max_y),
    .cmd             (cmd),
    .st              (st),
    .out_status      (out_status),
    .out_start_level (out_start_level)
  );

  // no item is taken while a result waits, and none appears in the transfer cycle after
  `HMQ_ASSERT_NOW(a_no_take_with_result, clk, rst_n, in_valid && !in_stall, !out_valid)
  `HMQ_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && !in_stall, !out_valid)
  // a start level is only reported by a walk
  `HMQ_ASSERT_NOW(a_level_only_walk, clk, rst_n, out_valid && (out_start_level != 3'd0),
                  (out_status == ST_VISIBLE) || (out_status == ST_OCCLUDED))

endmodule
`default_nettype wire

/* sv/hmq_ctrl.sv */
`default_nettype none
module hmq_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire            out_stall,
  input  hmq_pkg::stat_t st,
  output hmq_pkg::cmd_t  cmd
);
  import hmq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_BRD   = 10'b0000000100,
    S_BWR   = 10'b0000001000,
    S_QCHK  = 10'b0000010000,
    S_WENT  = 10'b0000100000,
    S_WRD   = 10'b0001000000,
    S_WEVAL = 10'b0010000000,
    S_WADV  = 10'b0100000000,
    S_RESP  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.res_status = ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.op)
          OP_QUERY: begin
            cmd.q_calc = 1'b1;
            state_nxt  = S_QCHK;
          end
          OP_BUILD: begin
            if (st.b_empty) begin
              cmd.res_set = 1'b1;
              state_nxt   = S_RESP;
            end else begin
              cmd.b_init = 1'b1;
              state_nxt  = S_BRD;
            end
          end
          OP_WRITE: begin
            cmd.wr_pixel = 1'b1;
            cmd.res_set  = 1'b1;
            state_nxt    = S_RESP;
          end
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_RESP;
          end
        endcase
      end
      S_BRD: begin
        cmd.b_rd = 1'b1;
        if (st.b_k3) state_nxt = S_BWR;
      end
      S_BWR: begin
        cmd.b_wr = 1'b1;
        if (st.b_last) begin
          cmd.res_set = 1'b1;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_BRD;
        end
      end
      S_QCHK: begin
        if (st.q_res != ST_DONE) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = st.q_res;
          state_nxt      = S_RESP;
        end else begin
          cmd.w_start = 1'b1;
          state_nxt   = S_WENT;
        end
      end
      S_WENT: begin
        if (st.f_empty) begin
          if (st.at_top) begin
            cmd.res_set    = 1'b1;
            cmd.res_top    = 1'b1;
            cmd.res_status = ST_OCCLUDED;
            state_nxt      = S_RESP;
          end else begin
            cmd.w_pop = 1'b1;
            state_nxt = S_WADV;
          end
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        cmd.w_rd  = 1'b1;
        state_nxt = S_WEVAL;
      end
      S_WEVAL: begin
        if (st.pix_clear) begin
          if (st.lvl_zero) begin
            cmd.res_set    = 1'b1;
            cmd.res_top    = 1'b1;
            cmd.res_status = ST_VISIBLE;
            state_nxt      = S_RESP;
          end else begin
            cmd.w_desc = 1'b1;
            state_nxt  = S_WENT;
          end
        end else begin
          state_nxt = S_WADV;
        end
      end
      S_WADV: begin
        if (st.f_end) begin
          if (st.at_top) begin
            cmd.res_set    = 1'b1;
            cmd.res_top    = 1'b1;
            cmd.res_status = ST_OCCLUDED;
            state_nxt      = S_RESP;
          end else begin
            // parent frame then moves past the pixel it descended from
            cmd.w_pop = 1'b1;
          end
        end else begin
          cmd.w_adv = 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_RESP: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/hmq_dp.sv */
`default_nettype none
module hmq_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [3:0]         cfg_wdata,
  input  wire  [1:0]         in_op,
  input  wire  [7:0]         in_pixel_x,
  input  wire  [7:0]         in_pixel_y,
  input  wire  [7:0]         in_pixel_value,
  input  wire  signed [15:0] in_rect_min_x,
  input  wire  signed [15:0] in_rect_max_x,
  input  wire  signed [15:0] in_rect_min_y,
  input  wire  signed [15:0] in_rect_max_y,
  input  hmq_pkg::cmd_t      cmd,
  output hmq_pkg::stat_t     st,
  output logic [2:0]         out_status,
  output logic [2:0]         out_start_level
);
  import hmq_pkg::*;

  logic [LogW-1:0]   side_log2_r;
  op_t               op_r;
  logic [CoordW-1:0] px_r, py_r, pv_r;
  logic signed [15:0] mnx_r, mxx_r, mny_r, mxy_r;

  logic [LogW-1:0]   lg, nlev;
  logic [CoordW:0]   side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_log2_r <= LogW'(MaxLog);
    end else if (cfg_we) begin
      side_log2_r <= cfg_wdata;
    end
  end

  always_comb begin
    lg = side_log2_r;
    if (side_log2_r < LogW'(2)) lg = LogW'(2);
    if (side_log2_r > LogW'(MaxLog)) lg = LogW'(MaxLog);
    nlev = lg - LogW'(1);
    if (nlev > LogW'(MaxLevels)) nlev = LogW'(MaxLevels);
    side = (CoordW+1)'(1) << lg;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      px_r  <= in_pixel_x;
      py_r  <= in_pixel_y;
      pv_r  <= in_pixel_value;
      mnx_r <= in_rect_min_x;
      mxx_r <= in_rect_max_x;
      mny_r <= in_rect_min_y;
      mxy_r <= in_rect_max_y;
    end
  end

  // query set-up: clip, classify and pick the start level
  logic signed [16:0] smax, mnx, mxx, mny, mxy, cx0, cx1, cy0, cy1;
  logic               outside, degen;
  logic [CoordW-1:0]  sx, sy, size;
  logic [LvlW-1:0]    raw_lvl, lvlc;
  logic [CoordW-1:0]  bx0_r, bx1_r, by0_r, by1_r;
  logic [LvlW-1:0]    top_r;
  status_t            q_res_r;

  always_comb begin
    smax = 17'(side) - 17'sd1;
    mnx = 17'(mnx_r);
    mxx = 17'(mxx_r);
    mny = 17'(mny_r);
    mxy = 17'(mxy_r);
    outside = (mxx < 0) || (mnx > smax) || (mxy < 0) || (mny > smax);
    cx0 = (mnx < 0) ? 17'sd0 : mnx;
    cx1 = (mxx > smax) ? smax : mxx;
    cy0 = (mny < 0) ? 17'sd0 : mny;
    cy1 = (mxy > smax) ? smax : mxy;
    degen = (cx1 <= cx0) || (cy1 <= cy0);
    sx = cx1[CoordW-1:0] - cx0[CoordW-1:0];
    sy = cy1[CoordW-1:0] - cy0[CoordW-1:0];
    size = (sx > sy) ? sx : sy;
    raw_lvl = '0;
    for (int i = 1; i < CoordW; i++) begin
      if (size[i]) raw_lvl = LvlW'(i);
    end
    lvlc = raw_lvl;
    if ({1'b0, raw_lvl} >= nlev) lvlc = LvlW'(nlev - LogW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.q_calc) begin
      q_res_r <= outside ? ST_OUTSIDE : (degen ? ST_DEGEN : ST_DONE);
      bx0_r   <= cx0[CoordW-1:0];
      bx1_r   <= cx1[CoordW-1:0];
      by0_r   <= cy0[CoordW-1:0];
      by1_r   <= cy1[CoordW-1:0];
      top_r   <= lvlc;
    end
  end

  // walk frames, one per level
  frame_t            frames_r [MaxLevels];
  logic [LvlW-1:0]   wlvl_r, newlvl;
  logic              fempty_r;
  frame_t            cur;
  logic [CoordW:0]   rx0, rx1, ry0, ry1, ex0, ex1, ey0, ey1;
  logic [CoordW-1:0] lx0, lx1, ly0, ly1;
  logic              e_empty;

  assign cur = frames_r[wlvl_r];

  always_comb begin
    newlvl = cmd.w_start ? top_r : (wlvl_r - LvlW'(1));
    lx0 = bx0_r >> newlvl;
    lx1 = bx1_r >> newlvl;
    ly0 = by0_r >> newlvl;
    ly1 = by1_r >> newlvl;
    if (cmd.w_start) begin
      rx0 = {1'b0, lx0};
      rx1 = {1'b0, lx1};
      ry0 = {1'b0, ly0};
      ry1 = {1'b0, ly1};
    end else begin
      rx0 = {cur.x, 1'b0};
      rx1 = {cur.x, 1'b1};
      ry0 = {cur.y, 1'b0};
      ry1 = {cur.y, 1'b1};
    end
    ex0 = (rx0 < {1'b0, lx0}) ? {1'b0, lx0} : rx0;
    ex1 = (rx1 > {1'b0, lx1}) ? {1'b0, lx1} : rx1;
    ey0 = (ry0 < {1'b0, ly0}) ? {1'b0, ly0} : ry0;
    ey1 = (ry1 > {1'b0, ly1}) ? {1'b0, ly1} : ry1;
    e_empty = (ex0 > ex1) || (ey0 > ey1);
  end

  always_ff @(posedge clk) begin
    if (cmd.w_start || cmd.w_desc) begin
      frames_r[newlvl] <= '{x: ex0[CoordW-1:0], y: ey0[CoordW-1:0], x1: ex1[CoordW-1:0],
                            y0: ey0[CoordW-1:0], y1: ey1[CoordW-1:0]};
      wlvl_r   <= newlvl;
      fempty_r <= e_empty;
    end else if (cmd.w_pop) begin
      wlvl_r <= wlvl_r + LvlW'(1);
    end else if (cmd.w_adv) begin
      if (cur.y < cur.y1) begin
        frames_r[wlvl_r].y <= cur.y + CoordW'(1);
      end else begin
        frames_r[wlvl_r].y <= cur.y0;
        frames_r[wlvl_r].x <= cur.x + CoordW'(1);
      end
    end
  end

  // build counters
  logic [LvlW-1:0]   blvl_r;
  logic [CoordW-1:0] bx_r, by_r, ds_m1;
  logic [1:0]        bk_r;
  logic [9:0]        acc_r, sum;
  logic              rv_r;
  logic [LogW-1:0]   bsh;
  logic              last_x, last_y;

  always_comb begin
    bsh    = lg - LogW'(blvl_r);
    ds_m1  = CoordW'(((CoordW+1)'(1) << bsh) - (CoordW+1)'(1));
    last_x = (bx_r == ds_m1);
    last_y = (by_r == ds_m1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= 1'b0;
    end else begin
      rv_r <= cmd.b_rd;
    end
  end

  logic [7:0] rd_data_r;

  assign sum = acc_r + 10'(rd_data_r);

  always_ff @(posedge clk) begin
    if (cmd.b_init) begin
      blvl_r <= LvlW'(1);
      bx_r   <= '0;
      by_r   <= '0;
      bk_r   <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.b_rd) bk_r <= bk_r + 2'd1;
      if (cmd.b_wr) begin
        acc_r <= '0;
        if (!last_x) begin
          bx_r <= bx_r + CoordW'(1);
        end else begin
          bx_r <= '0;
          if (!last_y) begin
            by_r <= by_r + CoordW'(1);
          end else begin
            by_r   <= '0;
            blvl_r <= blvl_r + LvlW'(1);
          end
        end
      end else if (rv_r) begin
        acc_r <= sum;
      end
    end
  end

  // pyramid store, single write port and one registered read port
  logic [7:0]       store [StoreDepth];
  logic [AddrW-1:0] src_addr, dst_addr, walk_addr, pix_addr, rd_addr, wr_addr;
  logic             in_map, rd_en, wr_en;
  logic [7:0]       wr_data;

  always_comb begin
    src_addr  = lvl_base(lg, blvl_r - LvlW'(1))
              + (AddrW'({by_r, bk_r[1]}) << (bsh + LogW'(1)))
              + AddrW'({bx_r, bk_r[0]});
    dst_addr  = lvl_base(lg, blvl_r) + (AddrW'(by_r) << bsh) + AddrW'(bx_r);
    walk_addr = lvl_base(lg, wlvl_r) + (AddrW'(cur.y) << (lg - LogW'(wlvl_r)))
              + AddrW'(cur.x);
    pix_addr  = (AddrW'(py_r) << lg) + AddrW'(px_r);
    in_map    = ({1'b0, px_r} < side) && ({1'b0, py_r} < side);
    rd_en     = cmd.b_rd || cmd.w_rd;
    rd_addr   = cmd.b_rd ? src_addr : walk_addr;
    wr_en     = (cmd.wr_pixel && in_map && (op_r == OP_WRITE)) || cmd.b_wr;
    wr_addr   = cmd.b_wr ? dst_addr : pix_addr;
    wr_data   = cmd.b_wr ? sum[9:2] : pv_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= store[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_status      <= ST_DONE;
      out_start_level <= '0;
    end else if (cmd.res_set) begin
      out_status      <= cmd.res_status;
      out_start_level <= cmd.res_top ? top_r : '0;
    end
  end

  always_comb begin
    st.op        = op_r;
    st.b_empty   = (nlev <= LogW'(1));
    st.b_k3      = (bk_r == 2'd3);
    st.b_last    = last_x && last_y && ({1'b0, blvl_r} == nlev - LogW'(1));
    st.q_res     = q_res_r;
    st.f_empty   = fempty_r;
    st.f_end     = (cur.x == cur.x1) && (cur.y == cur.y1);
    st.at_top    = (wlvl_r == top_r);
    st.lvl_zero  = (wlvl_r == '0);
    st.pix_clear = (rd_data_r < Opaque);
  end

endmodule
`default_nettype wire

/* tb/tb_hierarchical_occlusion_map_query_unit.sv */
`default_nettype none
module tb_hierarchical_occlusion_map_query_unit;
  import hmq_pkg::*;

  localparam int WatchLimit = 60000;
  localparam int ExpDepth   = 16;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [3:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_op;
  logic [7:0]         in_pixel_x;
  logic [7:0]         in_pixel_y;
  logic [7:0]         in_pixel_value;
  logic signed [15:0] in_rect_min_x;
  logic signed [15:0] in_rect_max_x;
  logic signed [15:0] in_rect_min_y;
  logic signed [15:0] in_rect_max_y;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_status;
  logic [2:0]         out_start_level;

  hierarchical_occlusion_map_query_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_pixel_value  (in_pixel_value),
    .in_rect_min_x   (in_rect_min_x),
    .in_rect_max_x   (in_rect_max_x),
    .in_rect_min_y   (in_rect_min_y),
    .in_rect_max_y   (in_rect_max_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_start_level (out_start_level)
  );

  // shadow pyramid and register
  logic [7:0] map_mem [0:StoreDepth-1];
  logic [3:0] side_reg;

  // expected results, written at the input transfer and read at the output transfer
  status_t    exp_status [0:ExpDepth-1];
  logic [2:0] exp_level [0:ExpDepth-1];
  int         exp_wr;
  int         exp_rd;

  int  mismatches;
  int  idle_cycles;
  int  stall_left;
  bit  calm;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int side_log();
    int v;
    v = side_reg;
    if (v < 2) v = 2;
    if (v > MaxLog) v = MaxLog;
    return v;
  endfunction

  function automatic int num_levels(int lg);
    return (lg - 1 > MaxLevels) ? MaxLevels : lg - 1;
  endfunction

  function automatic int level_offset(int lg, int lvl);
    int off;
    off = 0;
    for (int k = 0; k < lvl; k++) off += (1 << (lg - k)) * (1 << (lg - k));
    return off;
  endfunction

  function automatic int map_rd(int idx);
    return (idx < StoreDepth) ? int'(map_mem[idx]) : 0;
  endfunction

  // depth-first search for a see-through base pixel inside the box
  function automatic bit area_open(int lg, int lvl, int x0, int x1, int y0, int y1,
                                   int bx0, int bx1, int by0, int by1);
    int sd;
    int base;
    sd = 1 << (lg - lvl);
    base = level_offset(lg, lvl);
    if (x0 < (bx0 >> lvl)) x0 = bx0 >> lvl;
    if (x1 > (bx1 >> lvl)) x1 = bx1 >> lvl;
    if (y0 < (by0 >> lvl)) y0 = by0 >> lvl;
    if (y1 > (by1 >> lvl)) y1 = by1 >> lvl;
    if (x0 > x1 || y0 > y1) return 1'b0;
    for (int x = x0; x <= x1; x++) begin
      for (int y = y0; y <= y1; y++) begin
        if (map_rd(base + y * sd + x) < 255) begin
          if (lvl == 0) return 1'b1;
          if (area_open(lg, lvl - 1, x * 2, x * 2 + 1, y * 2, y * 2 + 1,
                        bx0, bx1, by0, by1)) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_item(input op_t op, input int px, input int py, input int pv,
                              input int mnx, input int mxx, input int mny, input int mxy);
    int lg;
    int sd;
    int levels;
    int sz;
    int lvl;
    int ds;
    int sb;
    int db;
    int r1;
    status_t st;
    lg = side_log();
    sd = 1 << lg;
    levels = num_levels(lg);
    st = ST_DONE;
    lvl = 0;
    case (op)
      OP_WRITE: begin
        if (px < sd && py < sd) map_mem[py * sd + px] = pv[7:0];
      end
      OP_BUILD: begin
        for (int l = 1; l < levels; l++) begin
          ds = 1 << (lg - l);
          sb = level_offset(lg, l - 1);
          db = level_offset(lg, l);
          for (int y = 0; y < ds; y++) begin
            for (int x = 0; x < ds; x++) begin
              r1 = sb + y * 4 * ds + x * 2;
              map_mem[db + y * ds + x] = 8'((map_rd(r1) + map_rd(r1 + 1) +
                map_rd(r1 + 2 * ds) + map_rd(r1 + 2 * ds + 1)) / 4);
            end
          end
        end
      end
      OP_QUERY: begin
        if (mxx < 0 || mnx > sd - 1 || mxy < 0 || mny > sd - 1) begin
          st = ST_OUTSIDE;
        end else begin
          if (mnx < 0) mnx = 0;
          if (mxx > sd - 1) mxx = sd - 1;
          if (mny < 0) mny = 0;
          if (mxy > sd - 1) mxy = sd - 1;
          if (mxx <= mnx || mxy <= mny) begin
            st = ST_DEGEN;
          end else begin
            sz = (mxx - mnx > mxy - mny) ? mxx - mnx : mxy - mny;
            while ((sz >> (lvl + 1)) != 0) lvl++;
            if (lvl >= levels) lvl = levels - 1;
            st = area_open(lg, lvl, mnx >> lvl, mxx >> lvl, mny >> lvl, mxy >> lvl,
                           mnx, mxx, mny, mxy) ? ST_VISIBLE : ST_OCCLUDED;
          end
        end
      end
      default: ;
    endcase
    exp_status[exp_wr % ExpDepth] = st;
    exp_level[exp_wr % ExpDepth] = 3'(lvl);
    exp_wr++;
  endtask

  // sender: called and returns at a falling edge
  task automatic send_item(input op_t op, input int px, input int py, input int pv,
                           input int mnx, input int mxx, input int mny, input int mxy);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    // the block sees only the port widths, rectangle edges as signed 16 bits
    px = px & 255;
    py = py & 255;
    pv = pv & 255;
    mnx = {{16{mnx[15]}}, mnx[15:0]};
    mxx = {{16{mxx[15]}}, mxx[15:0]};
    mny = {{16{mny[15]}}, mny[15:0]};
    mxy = {{16{mxy[15]}}, mxy[15:0]};
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_pixel_x = px[7:0];
    in_pixel_y = py[7:0];
    in_pixel_value = pv[7:0];
    in_rect_min_x = mnx[15:0];
    in_rect_max_x = mxx[15:0];
    in_rect_min_y = mny[15:0];
    in_rect_max_y = mxy[15:0];
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    predict_item(op, px, py, pv, mnx, mxx, mny, mxy);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_side(input int v);
    drain();
    cfg_wdata = v[3:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    side_reg = v[3:0];
  endtask

  task automatic put_pixel(input int x, input int y, input int v);
    send_item(OP_WRITE, x, y, v, 0, 0, 0, 0);
  endtask

  // writes every base pixel of the current side; each is opaque with a chance of opaque_pct percent
  task automatic fill_base(input int opaque_pct);
    int sd;
    sd = 1 << side_log();
    for (int y = 0; y < sd; y++) begin
      for (int x = 0; x < sd; x++) begin
        put_pixel(x, y, ($urandom_range(0, 99) < opaque_pct) ? 255 : $urandom_range(0, 254));
      end
    end
  endtask

  task automatic rand_query();
    int sd;
    int mnx;
    int mny;
    int span;
    sd = 1 << side_log();
    span = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, sd);
    mnx = $urandom_range(0, sd + 5) - 3;
    mny = $urandom_range(0, sd + 5) - 3;
    send_item(OP_QUERY, $urandom, $urandom, $urandom, mnx, mnx + span,
              mny, mny + $urandom_range(0, span + 1));
  endtask

  task automatic test_directed();
    // reset side is 256: writes and queries that read nothing
    put_pixel(0, 0, 0);
    put_pixel(255, 255, 255);
    put_pixel(170, 85, 170);
    put_pixel(85, 170, 85);
    send_item(OP_NONE, 255, 255, 255, -1, -1, -1, -1);
    send_item(OP_QUERY, 0, 0, 0, -32768, -1, 0, 10);
    send_item(OP_QUERY, 0, 0, 0, 256, 32767, 0, 10);
    send_item(OP_QUERY, 0, 0, 0, 0, 10, -32768, -1);
    send_item(OP_QUERY, 0, 0, 0, 0, 10, 256, 32767);
    send_item(OP_QUERY, 0, 0, 0, -32768, 32767, 5, 5);
    send_item(OP_QUERY, 0, 0, 0, 7, 3, -32768, 32767);
    send_item(OP_QUERY, 0, 0, 0, 300, -300, 300, -300);
    send_item(OP_QUERY, 0, 0, 0, 21845, -21846, -21846, 21845);
  endtask

  task automatic test_tiny_map();
    // values below 2 act as side 4, one level only
    set_side(0);
    fill_base(50);
    put_pixel(4, 0, 9);
    put_pixel(0, 200, 9);
    send_item(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, -32768, 32767, -32768, 32767);
    for (int i = 0; i < 8; i++) rand_query();
    set_side(2);
    for (int i = 0; i < 16; i++) put_pixel(i % 4, i / 4, 255);
    send_item(OP_QUERY, 0, 0, 0, 0, 3, 0, 3);
    put_pixel(3, 3, 254);
    send_item(OP_QUERY, 0, 0, 0, 0, 3, 0, 3);
    send_item(OP_QUERY, 0, 0, 0, 0, 2, 0, 2);
  endtask

  // runs on the map that test_wide_map leaves behind
  task automatic test_mixed_traffic();
    int r;
    send_item(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, 0, 7, 0, 7);
    for (int i = 0; i < 60; i++) begin
      if (i == 20) calm = 1'b1;
      if (i == 40) calm = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 20) put_pixel($urandom_range(0, 19), $urandom_range(0, 19),
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 255);
      else if (r < 28) send_item(OP_BUILD, $urandom, $urandom, $urandom, 0, 0, 0, 0);
      else if (r < 31) send_item(OP_NONE, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
      else if (r < 34) send_item(OP_QUERY, 0, 0, 0, $urandom, $urandom, $urandom, $urandom);
      else rand_query();
    end
  endtask

  task automatic test_wide_map();
    set_side(4);
    fill_base(92);
    send_item(OP_BUILD, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 30; i++) begin
      // hold off until the pipe is empty now and then
      if (i % 15 == 0) drain();
      rand_query();
    end
  endtask

  task automatic test_register_top();
    // anything above 8 acts as 8; only reads of written pixels allowed
    set_side(15);
    for (int i = 0; i < 8; i++) begin
      put_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      send_item(OP_QUERY, 0, 0, 0, $urandom_range(0, 32767) - 32768,
                $urandom_range(0, 32767) - 32768, $urandom, $urandom);
    end
    set_side(8);
    send_item(OP_QUERY, 0, 0, 0, 10, 10, 0, 255);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d level=%0d",
                                       out_status, out_start_level);
      end else begin
        if (out_status !== exp_status[exp_rd % ExpDepth] ||
            out_start_level !== exp_level[exp_rd % ExpDepth]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status=%0d level=%0d, got status=%0d level=%0d",
                     exp_status[exp_rd % ExpDepth], exp_level[exp_rd % ExpDepth],
                     out_status, out_start_level);
        end
        exp_rd++;
      end
      stall_left = calm ? 0 : $urandom_range(0, 3);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL hierarchical_occlusion_map_query_unit");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = '0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_pixel_value = '0;
    in_rect_min_x = '0;
    in_rect_max_x = '0;
    in_rect_min_y = '0;
    in_rect_max_y = '0;
    out_stall = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    exp_wr = 0;
    exp_rd = 0;
    mismatches = 0;
    idle_cycles = 0;
    side_reg = 4'd8;
    for (int i = 0; i < StoreDepth; i++) map_mem[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_tiny_map();
    test_wide_map();
    test_mixed_traffic();
    test_register_top();
    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && exp_wr == exp_rd) begin
      $display("PASS hierarchical_occlusion_map_query_unit");
    end else begin
      $display("FAIL hierarchical_occlusion_map_query_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
